[hw/rtl/meter_telegram_line_parser_top_defines.svh]
// Assertion macros for the meter telegram line parser.
`ifndef METER_TELEGRAM_LINE_PARSER_TOP_DEFINES_SVH
`define METER_TELEGRAM_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTLP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mtlp_pkg.sv]
// Types, constants and helper functions shared by the telegram line parser.
package mtlp_pkg;

   localparam int NUM_CODES  = 27;
   localparam int CODE_CHARS = 11;
   localparam int VALUE_BITS = 48;
   localparam int PROD_BITS  = VALUE_BITS + 10;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam logic [NUM_CODES-1:0]  STAR_MASK = 27'h007FFFE;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_F    = 8'h46;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_F   = 8'h66;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   localparam logic [3:0] LINE_POS_MAX = 4'd15;
   localparam logic [2:0] HEX_DIGITS   = 3'd4;
   localparam logic [2:0] HEX_DONE     = 3'd5;
   localparam logic [1:0] FRAC_DIGITS  = 2'd3;

   typedef logic [CODE_CHARS*8-1:0] code_text_type;

   // Data codes, first character in the top byte, padded with '#'.
   localparam code_text_type CODE_TAB [NUM_CODES] = '{
      "0-0:96.14.0", "1-0:1.8.0##", "1-0:1.8.1##", "1-0:1.8.2##", "1-0:1.8.3##",
      "1-0:1.8.4##", "1-0:2.8.0##", "1-0:2.8.1##", "1-0:2.8.2##", "1-0:2.8.3##",
      "1-0:2.8.4##", "1-0:1.7.0##", "1-0:2.7.0##", "1-0:32.7.0#", "1-0:52.7.0#",
      "1-0:72.7.0#", "1-0:31.7.0#", "1-0:51.7.0#", "1-0:71.7.0#", "0-0:96.7.21",
      "0-0:96.7.9#", "1-0:32.32.0", "1-0:52.32.0", "1-0:72.32.0",
      "1-0:32.36.0", "1-0:52.36.0", "1-0:72.36.0"
   };

   localparam logic [3:0] CODE_LEN [NUM_CODES] = '{
      4'd11, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
      4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd10,
      4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11
   };

   typedef enum logic {
      KIND_FIELD   = 1'b0,
      KIND_VERDICT = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic frozen;
      logic crc_match;
   } crc_status_type;

   typedef struct packed {
      logic point;
      logic bad;
      logic closed;
      logic open;
   } value_flags_type;

   typedef struct packed {
      result_kind_type       kind;
      logic [4:0]            field_id;
      logic [VALUE_BITS-1:0] value;
      logic [1:0]            scale_exp;
      logic                  checksum_ok;
   } result_item_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // Append one decimal digit, clamp at the maximum.
   function automatic logic [VALUE_BITS-1:0] sat_push(input logic [VALUE_BITS-1:0] v,
                                                      input logic [3:0] d);
      logic [VALUE_BITS+3:0] t;
      t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VALUE_BITS{1'b0}}, d};
      return (t[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_MAX : t[VALUE_BITS-1:0];
   endfunction

   function automatic logic [7:0] code_char(input int idx, input logic [3:0] pos);
      code_text_type txt;
      logic [7:0]    ch;
      txt = CODE_TAB[idx];
      ch  = 8'h00;
      for (int p = 0; p < CODE_CHARS; p++) begin
         if (pos == 4'(p)) begin
            ch = txt[(CODE_CHARS-1-p)*8 +: 8];
         end
      end
      return ch;
   endfunction

endpackage

[hw/rtl/mtlp_crc.sv]
// Running CRC-16 over the telegram and capture of the trailing hex checksum.
module mtlp_crc
   import mtlp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_fire,
   input  logic [7:0]     in_byte,
   output crc_status_type status
);

   logic [15:0] crc_ff, crc_in;
   logic        frozen_ff, frozen_in;
   logic [15:0] hex_ff, hex_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic       hex_valid;
   logic [3:0] hex_val;

   always_comb begin
      hex_valid = 1'b0;
      hex_val   = in_byte[3:0];
      if (in_byte >= CHAR_ZERO && in_byte <= CHAR_NINE) begin
         hex_valid = 1'b1;
      end else if ((in_byte >= CHAR_UP_A && in_byte <= CHAR_UP_F) ||
                   (in_byte >= CHAR_LOW_A && in_byte <= CHAR_LOW_F)) begin
         hex_valid = 1'b1;
         hex_val   = in_byte[3:0] + 4'd9;
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      frozen_in = frozen_ff;
      hex_in    = hex_ff;
      cnt_in    = cnt_ff;
      if (in_fire) begin
         priority if (in_byte == CHAR_NEWLINE) begin
            if (frozen_ff) begin
               // verdict given this item: start over
               crc_in    = CRC_INIT;
               frozen_in = 1'b0;
               hex_in    = 16'h0000;
               cnt_in    = 3'd0;
            end else begin
               crc_in = crc_byte(crc_ff, in_byte);
            end
         end else if (in_byte == CHAR_SLASH) begin
            crc_in    = crc_byte(CRC_INIT, in_byte);
            frozen_in = 1'b0;
            hex_in    = 16'h0000;
            cnt_in    = 3'd0;
         end else if (!frozen_ff) begin
            crc_in = crc_byte(crc_ff, in_byte);
            if (in_byte == CHAR_BANG) begin
               frozen_in = 1'b1;
               hex_in    = 16'h0000;
               cnt_in    = 3'd0;
            end
         end else if (cnt_ff < HEX_DIGITS) begin
            if (hex_valid) begin
               hex_in = {hex_ff[11:0], hex_val};
               cnt_in = cnt_ff + 3'd1;
            end else begin
               cnt_in = HEX_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         frozen_ff <= 1'b0;
         hex_ff    <= 16'h0000;
         cnt_ff    <= 3'd0;
      end else begin
         crc_ff    <= crc_in;
         frozen_ff <= frozen_in;
         hex_ff    <= hex_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign status.frozen    = frozen_ff;
   assign status.crc_match = (hex_ff == crc_ff);

endmodule

[hw/rtl/mtlp_line.sv]
// Data code match and value text decode for one telegram line.
module mtlp_line
   import mtlp_pkg::*;
#(
   parameter int VALUE_CHARS = 15
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_fire,
   input  logic [7:0]      in_byte,
   output logic            line_hit,
   output result_item_type line_item
);

   localparam int TLW = $clog2(VALUE_CHARS + 2);
   localparam logic [TLW-1:0] TEXT_LIMIT = TLW'(VALUE_CHARS);

   logic [3:0]            pos_ff, pos_in;
   logic [NUM_CODES-1:0]  cand_ff, cand_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            frac_ff, frac_in;
   value_flags_type       flags_ff, flags_in;
   logic                  stopped_ff, stopped_in;
   logic [TLW-1:0]        tlen_ff, tlen_in;

   logic       hit;
   logic [4:0] hit_id;
   logic       good;
   logic       star;
   logic [7:0] end_char;
   logic       is_digit;

   // First candidate whose code is complete wins.
   always_comb begin
      hit    = 1'b0;
      hit_id = 5'd0;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (!hit && cand_ff[i] && CODE_LEN[i] <= pos_ff) begin
            hit    = 1'b1;
            hit_id = 5'(i);
         end
      end
   end

   assign good = flags_ff.open && flags_ff.closed && !flags_ff.bad && (tlen_ff <= TEXT_LIMIT);

   always_comb begin
      line_item.kind        = KIND_FIELD;
      line_item.field_id    = hit_id;
      line_item.value       = good ? acc_ff : '0;
      line_item.scale_exp   = (good && (stopped_ff || STAR_MASK[hit_id])) ?
                              (FRAC_DIGITS - frac_ff) : 2'd0;
      line_item.checksum_ok = 1'b0;
   end
   assign line_hit = hit;

   assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);

   always_comb begin
      pos_in     = pos_ff;
      cand_in    = cand_ff;
      acc_in     = acc_ff;
      frac_in    = frac_ff;
      flags_in   = flags_ff;
      stopped_in = stopped_ff;
      tlen_in    = tlen_ff;
      star       = 1'b0;
      end_char   = CHAR_CLOSE;
      if (in_fire) begin
         if (in_byte == CHAR_NEWLINE) begin
            pos_in     = 4'd0;
            cand_in    = '1;
            acc_in     = '0;
            frac_in    = 2'd0;
            flags_in   = '0;
            stopped_in = 1'b0;
            tlen_in    = '0;
         end else begin
            if (pos_ff != LINE_POS_MAX) begin
               for (int i = 0; i < NUM_CODES; i++) begin
                  if (pos_ff < CODE_LEN[i] && code_char(i, pos_ff) != in_byte) begin
                     cand_in[i] = 1'b0;
                  end
               end
               pos_in = pos_ff + 4'd1;
            end
            star     = |(cand_in & STAR_MASK);
            end_char = star ? CHAR_STAR : CHAR_CLOSE;

            priority if (in_byte == CHAR_OPEN) begin
               acc_in     = '0;
               frac_in    = 2'd0;
               tlen_in    = '0;
               stopped_in = 1'b0;
               flags_in   = '0;
               flags_in.open = 1'b1;
            end else if (!flags_ff.open) begin
               // outside any value text
            end else if (flags_ff.closed) begin
               if (in_byte == end_char) begin
                  flags_in.bad = 1'b1;
               end
            end else if (in_byte == end_char) begin
               flags_in.closed = 1'b1;
            end else begin
               if (tlen_ff <= TEXT_LIMIT) begin
                  tlen_in = tlen_ff + TLW'(1);
               end
               if (is_digit) begin
                  if (!flags_ff.point) begin
                     acc_in = sat_push(acc_ff, in_byte[3:0]);
                  end else if (star && frac_ff < FRAC_DIGITS && !stopped_ff) begin
                     acc_in  = sat_push(acc_ff, in_byte[3:0]);
                     frac_in = frac_ff + 2'd1;
                  end
               end else if (in_byte == CHAR_POINT || in_byte == CHAR_NUL) begin
                  // a second point or a NUL stops the digits; scaling waits for output
                  if (flags_ff.point || in_byte == CHAR_NUL) begin
                     stopped_in = stopped_ff || star;
                  end
                  flags_in.point = 1'b1;
               end else begin
                  flags_in.bad = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 4'd0;
         cand_ff    <= '1;
         acc_ff     <= '0;
         frac_ff    <= 2'd0;
         flags_ff   <= '0;
         stopped_ff <= 1'b0;
         tlen_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         cand_ff    <= cand_in;
         acc_ff     <= acc_in;
         frac_ff    <= frac_in;
         flags_ff   <= flags_in;
         stopped_ff <= stopped_in;
         tlen_ff    <= tlen_in;
      end
   end

endmodule

[hw/rtl/mtlp_scale.sv]
// Result stage: scales unit values to thousandths and holds the output item.
module mtlp_scale
   import mtlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  result_item_type       in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output result_kind_type       out_kind,
   output logic [4:0]            out_field_id,
   output logic [VALUE_BITS-1:0] out_value,
   output logic                  out_checksum_ok
);

   logic            s1_valid_ff, s1_valid_in;
   result_item_type s1_item_ff;
   logic            o_valid_ff, o_valid_in;
   result_kind_type o_kind_ff;
   logic [4:0]      o_id_ff;
   logic [VALUE_BITS-1:0] o_value_ff;
   logic            o_ok_ff;

   logic                  out_free;
   logic [PROD_BITS-1:0]  wide;
   logic [PROD_BITS-1:0]  prod;
   logic [VALUE_BITS-1:0] scaled;

   assign out_free = !o_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      o_valid_in  = o_valid_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
      end
      if (out_free) begin
         o_valid_in = s1_valid_ff;
      end
   end

   // Multiply by 1, 10, 100 or 1000 with shifts and adds, clamp.
   assign wide = {{(PROD_BITS-VALUE_BITS){1'b0}}, s1_item_ff.value};
   always_comb begin
      unique case (s1_item_ff.scale_exp)
         2'd0:    prod = wide;
         2'd1:    prod = (wide << 3) + (wide << 1);
         2'd2:    prod = (wide << 6) + (wide << 5) + (wide << 2);
         default: prod = (wide << 10) - (wide << 4) - (wide << 3);
      endcase
      scaled = (prod[PROD_BITS-1:VALUE_BITS] != '0) ? VALUE_MAX : prod[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_item_ff <= in_item;
      end
      if (out_free && s1_valid_ff) begin
         o_kind_ff  <= s1_item_ff.kind;
         o_id_ff    <= s1_item_ff.field_id;
         o_value_ff <= scaled;
         o_ok_ff    <= s1_item_ff.checksum_ok;
      end
   end

   assign out_valid       = o_valid_ff;
   assign out_kind        = o_kind_ff;
   assign out_field_id    = o_id_ff;
   assign out_value       = o_value_ff;
   assign out_checksum_ok = o_ok_ff;

endmodule

[hw/rtl/meter_telegram_line_parser_top.sv]
// A result passes the scale stage register and then the output register before it leaves on rsp.
// Throughput: one byte per cycle; req stalls only when both result registers are full and rsp is not ready.
// CRC, hex capture, code match and digit accumulate each finish in the cycle of the byte.
// Unit values are scaled to thousandths in the stage between the two result registers.
// Reset: synchronous, active high; clears CRC, capture, line state and result valids.
`include "meter_telegram_line_parser_top_defines.svh"

module meter_telegram_line_parser_top
   import mtlp_pkg::*;
#(
   parameter int VALUE_CHARS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [4:0] field_id, [52:5] field_value, [53] checksum_ok
   output logic        rsp_tuser    // [0] result_kind
);

   logic            fire;
   logic            is_newline;
   crc_status_type  crc_status;
   logic            line_hit;
   result_item_type line_item;
   result_item_type res_item;
   logic            res_valid;
   logic            stage_ready;

   result_kind_type       out_kind;
   logic [4:0]            out_field_id;
   logic [VALUE_BITS-1:0] out_value;
   logic                  out_checksum_ok;

   assign req_tready = stage_ready;
   assign fire       = req_tvalid && req_tready;
   assign is_newline = (req_tdata == CHAR_NEWLINE);

   mtlp_crc u_crc (
      .clock   (clock),
      .reset   (reset),
      .in_fire (fire),
      .in_byte (req_tdata),
      .status  (crc_status)
   );

   mtlp_line #(
      .VALUE_CHARS (VALUE_CHARS)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (fire),
      .in_byte   (req_tdata),
      .line_hit  (line_hit),
      .line_item (line_item)
   );

   // Verdict takes the line over any field match.
   always_comb begin
      res_item = line_item;
      if (crc_status.frozen) begin
         res_item.kind        = KIND_VERDICT;
         res_item.field_id    = 5'd0;
         res_item.value       = '0;
         res_item.scale_exp   = 2'd0;
         res_item.checksum_ok = crc_status.crc_match;
      end
   end
   assign res_valid = fire && is_newline && (crc_status.frozen || line_hit);

   mtlp_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (res_valid),
      .in_ready        (stage_ready),
      .in_item         (res_item),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_kind        (out_kind),
      .out_field_id    (out_field_id),
      .out_value       (out_value),
      .out_checksum_ok (out_checksum_ok)
   );

   assign rsp_tdata = {2'b00, out_checksum_ok, out_value, out_field_id};
   assign rsp_tuser = out_kind;

   `MTLP_ASSERT_IMPLY(a_verdict_clean, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[52:0] == 53'd0, "verdict item carries field data")
   `MTLP_ASSERT_IMPLY(a_field_clean, clock, reset, rsp_tvalid && !rsp_tuser, !rsp_tdata[53] && rsp_tdata[4:0] <= 5'd26, "field item malformed")
   `MTLP_ASSERT_NEXT(a_slash_unfreezes, clock, reset, fire && req_tdata == CHAR_SLASH, !crc_status.frozen, "slash left CRC frozen")
   `MTLP_ASSERT_NEXT(a_bang_freezes, clock, reset, fire && req_tdata == CHAR_BANG && !crc_status.frozen, crc_status.frozen, "bang did not freeze CRC")

endmodule

[dv/tb_line_parser_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard package: byte-level parser predictor and result checker for the telegram parser.
package tb_line_parser_pkg;
   import mtlp_pkg::result_kind_type;
   import mtlp_pkg::KIND_FIELD;
   import mtlp_pkg::KIND_VERDICT;

   localparam int          N_CODES     = 27;
   localparam int          TEXT_LIMIT  = 15;
   localparam int          POS_LIMIT   = 15;
   localparam bit [26:0]   UNIT_FIELDS = 27'h007FFFE;
   localparam bit [47:0]   VALUE_TOP   = '1;

   localparam bit [7:0] CH_NUL     = 8'h00;
   localparam bit [7:0] CH_NEWLINE = 8'h0A;
   localparam bit [7:0] CH_BANG    = 8'h21;
   localparam bit [7:0] CH_OPEN    = 8'h28;
   localparam bit [7:0] CH_CLOSE   = 8'h29;
   localparam bit [7:0] CH_STAR    = 8'h2A;
   localparam bit [7:0] CH_POINT   = 8'h2E;
   localparam bit [7:0] CH_SLASH   = 8'h2F;
   localparam bit [7:0] CH_ZERO    = 8'h30;

   // Data codes in table order; the index is the reported field id.
   function automatic string code_name(input int idx);
      case (idx)
         0:  return "0-0:96.14.0";
         1:  return "1-0:1.8.0";
         2:  return "1-0:1.8.1";
         3:  return "1-0:1.8.2";
         4:  return "1-0:1.8.3";
         5:  return "1-0:1.8.4";
         6:  return "1-0:2.8.0";
         7:  return "1-0:2.8.1";
         8:  return "1-0:2.8.2";
         9:  return "1-0:2.8.3";
         10: return "1-0:2.8.4";
         11: return "1-0:1.7.0";
         12: return "1-0:2.7.0";
         13: return "1-0:32.7.0";
         14: return "1-0:52.7.0";
         15: return "1-0:72.7.0";
         16: return "1-0:31.7.0";
         17: return "1-0:51.7.0";
         18: return "1-0:71.7.0";
         19: return "0-0:96.7.21";
         20: return "0-0:96.7.9";
         21: return "1-0:32.32.0";
         22: return "1-0:52.32.0";
         23: return "1-0:72.32.0";
         24: return "1-0:32.36.0";
         25: return "1-0:52.36.0";
         default: return "1-0:72.36.0";
      endcase
   endfunction

   // Reflected CRC-16, polynomial 0xA001, one byte.
   function automatic bit [15:0] crc16_step(input bit [15:0] c, input bit [7:0] b);
      bit [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   // Shift in one decimal digit, clamp at the top of the value range.
   function automatic bit [47:0] append_digit(input bit [47:0] v, input int unsigned d);
      longint unsigned w;
      longint unsigned top;
      w   = v;
      top = VALUE_TOP;
      if (w > (top - d) / 10) return VALUE_TOP;
      return 48'(w * 10 + d);
   endfunction

   class line_parser_scoreboard;
      typedef struct {
         result_kind_type kind;
         bit [4:0]        field_id;
         bit [47:0]       value;
         bit              checksum_ok;
      } parse_result_type;

      parse_result_type awaited_results[$];

      int mismatches;
      int results_checked;
      int predicted_total;
      int fields_predicted;
      int verdicts_predicted;
      int failing_verdicts;
      int saturated_values;
      int zero_values;

      // parser state
      bit [15:0] crc;
      bit        crc_frozen;
      bit [15:0] hex_word;
      int        hex_digits;
      int        line_pos;
      bit [26:0] candidates;
      bit [47:0] value;
      int        frac_digits;
      bit        text_open;
      bit        text_closed;
      bit        text_bad;
      bit        point_seen;
      int        text_len;

      function new();
         crc        = '0;
         crc_frozen = 1'b0;
         hex_word   = '0;
         hex_digits = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_pos    = 0;
         candidates  = '1;
         value       = '0;
         frac_digits = 0;
         text_open   = 1'b0;
         text_closed = 1'b0;
         text_bad    = 1'b0;
         point_seen  = 1'b0;
         text_len    = 0;
      endfunction

      function void stop_digits(bit is_unit);
         point_seen = 1'b1;
         if (is_unit) begin
            while (frac_digits < 3) begin
               value = append_digit(value, 0);
               frac_digits++;
            end
         end
      endfunction

      function void add_result(result_kind_type kind, int id, bit [47:0] v, bit ok);
         parse_result_type r;
         r.kind        = kind;
         r.field_id    = 5'(id);
         r.value       = v;
         r.checksum_ok = ok;
         awaited_results.push_back(r);
         predicted_total++;
      endfunction

      // End of line: checksum verdict while frozen, else the first matching code.
      function void end_line(bit [7:0] b);
         string     code;
         bit [47:0] v;
         bit        found;
         if (crc_frozen) begin
            add_result(KIND_VERDICT, 0, '0, hex_word == crc);
            verdicts_predicted++;
            if (hex_word != crc) failing_verdicts++;
            crc        = '0;
            crc_frozen = 1'b0;
            hex_word   = '0;
            hex_digits = 0;
         end else begin
            crc   = crc16_step(crc, b);
            found = 1'b0;
            for (int i = 0; i < N_CODES; i++) begin
               code = code_name(i);
               if (!found && candidates[i] && code.len() <= line_pos) begin
                  found = 1'b1;
                  v     = '0;
                  if (text_open && text_closed && !text_bad && text_len <= TEXT_LIMIT) begin
                     v = value;
                     if (UNIT_FIELDS[i]) begin
                        for (int f = frac_digits; f < 3; f++) v = append_digit(v, 0);
                     end
                  end
                  add_result(KIND_FIELD, i, v, 1'b0);
                  fields_predicted++;
                  if (v == VALUE_TOP) saturated_values++;
                  if (v == '0) zero_values++;
               end
            end
         end
         clear_line();
      endfunction

      function void parse_byte(bit [7:0] b);
         string    code;
         int       nib;
         bit       is_unit;
         bit [7:0] close_ch;
         if (b == CH_NEWLINE) begin
            end_line(b);
            return;
         end
         // checksum span and hex capture
         if (b == CH_SLASH) begin
            crc        = crc16_step('0, b);
            crc_frozen = 1'b0;
            hex_word   = '0;
            hex_digits = 0;
         end else if (!crc_frozen) begin
            crc = crc16_step(crc, b);
            if (b == CH_BANG) begin
               crc_frozen = 1'b1;
               hex_word   = '0;
               hex_digits = 0;
            end
         end else if (hex_digits < 4) begin
            nib = -1;
            if (b >= "0" && b <= "9") nib = b - "0";
            else if (b >= "A" && b <= "F") nib = b - "A" + 10;
            else if (b >= "a" && b <= "f") nib = b - "a" + 10;
            if (nib >= 0) begin
               hex_word = {hex_word[11:0], 4'(nib)};
               hex_digits++;
            end else begin
               hex_digits = 5;
            end
         end
         // drop codes whose text differs at this position
         if (line_pos < POS_LIMIT) begin
            for (int i = 0; i < N_CODES; i++) begin
               code = code_name(i);
               if (line_pos < code.len() && code[line_pos] != b) candidates[i] = 1'b0;
            end
            line_pos++;
         end
         // value text
         is_unit  = (candidates & UNIT_FIELDS) != '0;
         close_ch = is_unit ? CH_STAR : CH_CLOSE;
         if (b == CH_OPEN) begin
            value       = '0;
            frac_digits = 0;
            text_len    = 0;
            text_open   = 1'b1;
            text_closed = 1'b0;
            text_bad    = 1'b0;
            point_seen  = 1'b0;
         end else if (!text_open) begin
            // outside any value text
         end else if (text_closed) begin
            if (b == close_ch) text_bad = 1'b1;
         end else if (b == close_ch) begin
            text_closed = 1'b1;
         end else begin
            if (text_len <= TEXT_LIMIT) text_len++;
            if (b >= "0" && b <= "9") begin
               if (!point_seen) begin
                  value = append_digit(value, b - "0");
               end else if (is_unit && frac_digits < 3) begin
                  value = append_digit(value, b - "0");
                  frac_digits++;
               end
            end else if (b == CH_POINT) begin
               if (!point_seen) point_seen = 1'b1;
               else stop_digits(is_unit);
            end else if (b == CH_NUL) begin
               stop_digits(is_unit);
            end else begin
               text_bad = 1'b1;
            end
         end
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
      endfunction

      // rsp_tdata: [4:0] field_id, [52:5] field_value, [53] checksum_ok
      function void check_result(result_kind_type kind, logic [55:0] data);
         parse_result_type want;
         if (awaited_results.size() == 0) begin
            complain($sformatf("result with none pending: kind=%0d data=%h", kind, data));
            return;
         end
         want = awaited_results.pop_front();
         results_checked++;
         if (kind !== want.kind || data[4:0] !== want.field_id ||
             data[52:5] !== want.value || data[53] !== want.checksum_ok) begin
            complain($sformatf({"expected kind=%0d id=%0d value=%0d ok=%0d, ",
                                "got kind=%0d id=%0d value=%0d ok=%0d"},
                               want.kind, want.field_id, want.value, want.checksum_ok,
                               kind, data[4:0], data[52:5], data[53]));
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function int failures();
         return mismatches + awaited_results.size();
      endfunction
   endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top: streams telegram bytes into the line parser and checks every result.
module tb_top;
   import mtlp_pkg::result_kind_type;
   import tb_line_parser_pkg::*;

   localparam int RANDOM_BYTES = 700;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;            // [4:0] field_id, [52:5] field_value, [53] checksum_ok
   logic        rsp_tuser;            // [0] result_kind

   int        send_idle_pct = 0;
   int        rsp_idle_pct  = 0;
   int        hold_request  = 0;
   int        hold_left     = 0;
   int        cycle_count   = 0;
   int        bytes_sent    = 0;
   bit [15:0] gen_crc       = '0;
   bit [7:0]  line_buf[$];

   line_parser_scoreboard sb;

   meter_telegram_line_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
         $display("FAIL meter_telegram_line_parser_top");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request <= 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.parse_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(result_kind_type'(rsp_tuser), rsp_tdata);
      end
   end

   task automatic send_byte(input bit [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      // track the telegram CRC so well-formed telegrams carry a matching checksum
      gen_crc = (b == CH_SLASH) ? crc16_step('0, b) : crc16_step(gen_crc, b);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf.delete();
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void put_digits(int count);
      repeat (count) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
   endfunction

   // Value group, mostly well formed; the rest breaks it in one of several ways.
   function automatic void put_value(bit is_unit);
      int       mode;
      int       ilen;
      bit [7:0] close_ch;
      mode     = $urandom_range(99);
      close_ch = is_unit ? CH_STAR : CH_CLOSE;
      if (mode >= 90) put_text("(ERR)");
      line_buf.push_back(CH_OPEN);
      ilen = (mode >= 60 && mode < 65) ? $urandom_range(11, 16) : $urandom_range(0, 6);
      put_digits(ilen);
      if (mode >= 65 && mode < 70) line_buf.push_back(8'("A" + $urandom_range(25)));
      if (mode >= 70 && mode < 75) line_buf.push_back(CH_NUL);
      if ($urandom_range(3) != 0) begin
         line_buf.push_back(CH_POINT);
         put_digits($urandom_range(0, 5));
      end
      if (mode >= 75 && mode < 80) begin
         line_buf.push_back(CH_POINT);
         put_digits(2);
      end
      if (mode >= 85 && mode < 90) return;
      line_buf.push_back(close_ch);
      if (is_unit) put_text("kWh)");
      if (mode >= 80 && mode < 85) line_buf.push_back(close_ch);
   endfunction

   function automatic void put_data_line();
      int id;
      id = $urandom_range(N_CODES - 1);
      put_text(code_name(id));
      if ($urandom_range(15) == 0) put_text(".1");
      put_value(UNIT_FIELDS[id]);
      put_text("\015\n");
   endfunction

   function automatic void put_noise_line();
      string prefix;
      if ($urandom_range(1) != 0) begin
         prefix = code_name($urandom_range(N_CODES - 1));
         put_text(prefix.substr(0, $urandom_range(0, 8)));
      end
      repeat ($urandom_range(0, 20)) line_buf.push_back(8'($urandom_range(255)));
      line_buf.push_back(CH_NEWLINE);
   endfunction

   task automatic send_telegram(input bit with_checksum);
      int    mode;
      string sum;
      put_text("/ISK5MT382-1000\015\n\015\n");
      repeat ($urandom_range(1, 5)) put_data_line();
      send_line();
      if (!with_checksum) return;
      send_byte(CH_BANG);
      mode = $urandom_range(9);
      if (mode < 6) sum = $sformatf("%04X", gen_crc);
      else if (mode == 6) sum = $sformatf("%04x", gen_crc);
      else if (mode == 7) sum = $sformatf("%04X", gen_crc ^ (16'h1 << $urandom_range(15)));
      else if (mode == 8) sum = $sformatf("%02X", gen_crc[15:8]);
      else sum = "";
      put_text({sum, "\015\n"});
      send_line();
   endtask

   task automatic send_chunk();
      int r;
      r = $urandom_range(99);
      if (r < 65) begin
         send_telegram(1'b1);
      end else if (r < 80) begin
         put_data_line();
         send_line();
      end else if (r < 88) begin
         put_noise_line();
         send_line();
      end else if (r < 94) begin
         send_telegram(1'b0);
      end else begin
         // stray checksum marker followed by junk
         line_buf.push_back(CH_BANG);
         put_noise_line();
         send_line();
      end
   endtask

   // Hold the result side off while lines keep coming, so the input stalls.
   task automatic fill_and_stall();
      hold_request <= HOLD_CYCLES;
      repeat (10) put_data_line();
      send_line();
      wait_for_results();
   endtask

   task automatic send_directed();
      put_text("0-0:96.14.0(281474976710655)\015\n");
      put_text("1-0:2.7.0(999999999999*kW)\015\n");
      put_text("1-0:1.8.1(281474976710.655*kWh)\015\n");
      put_text("1-0:32.7.0(230.1*V)\015\n");
      put_text("0-0:96.7.21(00004)\015\n");
      put_text("1-0:1.7.0(1.2");
      line_buf.push_back(CH_NUL);
      put_text("5*kW)");
      line_buf.push_back(8'hFF);
      put_text("\015\n1-0:2.8.0(1..5*kWh)\015\n1-0:52.7.0(12*V*)\015\n");
      send_line();
      send_byte(CH_BANG);
      put_text({$sformatf("%04x", gen_crc), "\015\n"});
      // slash and bang while frozen, then a verdict on a data line
      put_text("/X\015\n!12/34\015\n!!AB\015\n1-0:1.8.0(5)!00\015\n");
      send_line();
      wait_for_results();
   endtask

   initial begin
      int start_bytes;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_directed();
      start_bytes = bytes_sent;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 71 : 0;
         rsp_idle_pct  = (phase == 0) ? 71 : (phase == 1) ? 24 : 0;
         if (phase == 2) fill_and_stall();
         while (bytes_sent - start_bytes < RANDOM_BYTES * (phase + 1) / 3) begin
            send_chunk();
         end
      end
      wait_for_results();
      repeat (12) @(posedge clock);
      $display("Covered %0d bytes, %0d results checked: %0d field values (%0d saturated, %0d zero)",
               bytes_sent, sb.results_checked, sb.fields_predicted, sb.saturated_values,
               sb.zero_values);
      $display("and %0d checksum verdicts (%0d failing), under three idle mixes and a %0d-cycle hold-off",
               sb.verdicts_predicted, sb.failing_verdicts, HOLD_CYCLES);
      if (sb.failures() == 0) begin
         $display("PASS meter_telegram_line_parser_top");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("FAIL meter_telegram_line_parser_top");
      end
      $finish;
   end

endmodule
